/* design/button_tap_event_classifier_macros.svh */
// Assertion macros for the button tap event classifier.
`ifndef BUTTON_TAP_EVENT_CLASSIFIER_MACROS_SVH
`define BUTTON_TAP_EVENT_CLASSIFIER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset
`define BTEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define BTEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define BTEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BTEC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/btec_pkg.sv */
// Types and constants of the button tap event classifier.
`timescale 1ns / 1ps

package btec_pkg;

  // Press/release phase codes
  typedef enum logic [3:0] {
    PH_RELEASED    = 4'd0,
    PH_T1_PRESS_B  = 4'd1,
    PH_T1_PRESS_E  = 4'd2,
    PH_T1_REL_B    = 4'd3,
    PH_T1_REL_E    = 4'd4,
    PH_T2_PRESS_B  = 4'd5,
    PH_T2_PRESS_E  = 4'd6,
    PH_T2_REL_B    = 4'd7,
    PH_T2_REL_E    = 4'd8,
    PH_T3_PRESS_B  = 4'd9,
    PH_T3_PRESS_E  = 4'd10,
    PH_T3_REL_B    = 4'd11,
    PH_T3_REL_E    = 4'd12,
    PH_LONG        = 4'd13,
    PH_HOLD        = 4'd14,
    PH_DONE        = 4'd15
  } phase_t;

  // Event codes reported per item
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_TAP    = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_TRIPLE = 3'd3,
    EV_LONG   = 3'd4,
    EV_HOLD   = 3'd5
  } event_t;

  // Configuration register indexes
  localparam logic [2:0] REG_ACTIVE_LEVEL = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [2:0] REG_GLITCH       = 3'd2;
  localparam logic [2:0] REG_TAP_MAX      = 3'd3;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd4;
  localparam logic [2:0] REG_HOLD         = 3'd5;
  localparam logic [2:0] REG_TAP_GAP      = 3'd6;

  // Register reset values
  localparam logic        RST_ACTIVE_LEVEL = 1'b1;
  localparam logic [15:0] RST_DEBOUNCE     = 16'd20;
  localparam logic [15:0] RST_GLITCH       = 16'd50;
  localparam logic [15:0] RST_TAP_MAX      = 16'd500;
  localparam logic [15:0] RST_LONG_PRESS   = 16'd1000;
  localparam logic [15:0] RST_HOLD         = 16'd3000;
  localparam logic [15:0] RST_TAP_GAP      = 16'd300;

endpackage

/* design/button_tap_event_classifier.sv */
// out_valid rises once an item has passed the input register and then the result
// register; a result register that is full and not drained holds the item in the input register.
// Throughput: one item per cycle; the single compare stage updating phase and edge
// stamp sets that figure, and it is held while the result register can drain.
// Reset (rst_n low, synchronous): phase released, edge stamp 0, registers to defaults,
// both pipeline stages empty.
`timescale 1ns / 1ps
`include "button_tap_event_classifier_macros.svh"

module button_tap_event_classifier
  import btec_pkg::*;
#(
  parameter int STAMP_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_pin_level,
  input  logic [31:0] in_now_ms,
  // event channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_code,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // compare width: one bit above the stamp covers the 17-bit threshold sum
  localparam int CMP_W = STAMP_BITS + 1;

  // configuration registers
  logic        active_level_r;
  logic [15:0] debounce_r, glitch_r, tap_max_r, long_press_r, hold_r, tap_gap_r;

  // input stage
  logic                  s0_valid_r;
  logic                  s0_pin_r;
  logic [STAMP_BITS-1:0] s0_now_r;

  // result stage
  logic   out_valid_r;
  event_t out_event_r;

  // classifier state
  phase_t                phase_r, phase_nxt;
  logic [STAMP_BITS-1:0] edge_r, edge_nxt;

  logic   s0_advance;
  logic   pressed;
  logic   closing;
  logic   adv_release;
  phase_t phase_a;
  event_t ev_nxt;
  logic [STAMP_BITS-1:0] elapsed;
  logic [CMP_W-1:0]      el_c;
  logic [16:0]           gap_hold;

  assign cfg_ready  = 1'b1;
  assign s0_advance = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s0_valid_r || s0_advance;
  assign out_valid      = out_valid_r;
  assign out_event_code = out_event_r;

  // configuration writes; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_level_r <= RST_ACTIVE_LEVEL;
      debounce_r     <= RST_DEBOUNCE;
      glitch_r       <= RST_GLITCH;
      tap_max_r      <= RST_TAP_MAX;
      long_press_r   <= RST_LONG_PRESS;
      hold_r         <= RST_HOLD;
      tap_gap_r      <= RST_TAP_GAP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ACTIVE_LEVEL: active_level_r <= cfg_data[0];
        REG_DEBOUNCE:     debounce_r     <= cfg_data;
        REG_GLITCH:       glitch_r       <= cfg_data;
        REG_TAP_MAX:      tap_max_r      <= cfg_data;
        REG_LONG_PRESS:   long_press_r   <= cfg_data;
        REG_HOLD:         hold_r         <= cfg_data;
        REG_TAP_GAP:      tap_gap_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_pin_r <= in_pin_level;
      s0_now_r <= STAMP_BITS'(in_now_ms);
    end
  end

  // elapsed time since the last edge, wrapping with the stamp width
  assign pressed  = (s0_pin_r == active_level_r);
  assign elapsed  = s0_now_r - edge_r;
  assign el_c     = {1'b0, elapsed};
  assign gap_hold = {1'b0, tap_gap_r} + {1'b0, hold_r};

  // phase update for the item in the input stage
  always_comb begin
    phase_a  = phase_r;
    edge_nxt = edge_r;
    ev_nxt   = EV_NONE;
    closing  = 1'b0;

    // first pass: release, new press, sequence close or debounce
    if (!pressed && phase_r == PH_DONE) begin
      phase_a = PH_RELEASED;
    end else if (pressed && phase_r == PH_RELEASED) begin
      phase_a  = PH_T1_PRESS_B;
      edge_nxt = s0_now_r;
    end else if ((!pressed && el_c > CMP_W'(tap_gap_r)) || el_c > CMP_W'(gap_hold)) begin
      closing = 1'b1;
      phase_a = PH_DONE;
      case (phase_r)
        PH_T1_REL_E: ev_nxt = EV_TAP;
        PH_T2_REL_E: ev_nxt = EV_DOUBLE;
        PH_T3_REL_E: ev_nxt = EV_TRIPLE;
        PH_LONG:     ev_nxt = EV_LONG;
        PH_HOLD:     ev_nxt = EV_HOLD;
        default:     ev_nxt = EV_NONE;
      endcase
    end else if (el_c > CMP_W'(debounce_r)) begin
      case (phase_r)
        PH_T1_PRESS_B: phase_a = PH_T1_PRESS_E;
        PH_T1_REL_B:   phase_a = PH_T1_REL_E;
        PH_T2_PRESS_B: phase_a = PH_T2_PRESS_E;
        PH_T2_REL_B:   phase_a = PH_T2_REL_E;
        PH_T3_PRESS_B: phase_a = PH_T3_PRESS_E;
        PH_T3_REL_B:   phase_a = PH_T3_REL_E;
        default: ;
      endcase
    end

    // second pass on the settled phase; elapsed is unchanged unless a new
    // press was just stamped, which leaves nothing to do here
    phase_nxt = phase_a;
    if (!closing) begin
      case (phase_a)
        PH_T1_PRESS_E: begin
          if (!pressed) begin
            if (el_c < CMP_W'(glitch_r)) begin
              phase_nxt = PH_RELEASED;
            end else if (el_c < CMP_W'(tap_max_r)) begin
              phase_nxt = PH_T1_REL_B;
              edge_nxt  = s0_now_r;
            end
          end else if (el_c > CMP_W'(long_press_r)) begin
            phase_nxt = PH_LONG;
          end
        end
        PH_LONG: begin
          if (el_c > CMP_W'(hold_r)) phase_nxt = PH_HOLD;
        end
        PH_T1_REL_E: begin
          if (pressed) begin
            phase_nxt = PH_T2_PRESS_B;
            edge_nxt  = s0_now_r;
          end
        end
        PH_T2_PRESS_E: begin
          if (!pressed) begin
            phase_nxt = PH_T2_REL_B;
            edge_nxt  = s0_now_r;
          end
        end
        PH_T2_REL_E: begin
          if (pressed) begin
            phase_nxt = PH_T3_PRESS_B;
            edge_nxt  = s0_now_r;
          end
        end
        PH_T3_PRESS_E: begin
          if (!pressed) begin
            phase_nxt = PH_T3_REL_B;
            edge_nxt  = s0_now_r;
          end
        end
        default: ;
      endcase
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RELEASED;
      edge_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s0_advance) begin
        phase_r <= phase_nxt;
        edge_r  <= edge_nxt;
      end
      if (s0_advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_advance) begin
      out_event_r <= ev_nxt;
    end
  end

  // released item leaving the finished phase
  assign adv_release = s0_advance && phase_r == PH_DONE && !pressed;

  // checks
  `BTEC_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, s0_advance, out_valid_r)
  `BTEC_ASSERT_NEXT(a_event_closes, clk, rst_n, s0_advance && ev_nxt != EV_NONE, phase_r == PH_DONE)
  `BTEC_ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_ready, s0_valid_r && out_valid_r && !out_ready)
  `BTEC_ASSERT_NEXT(a_done_release, clk, rst_n, adv_release, phase_r == PH_RELEASED)

endmodule
